FILE: hdl/hlsh_pkg.sv
// ----------------------------------------------------------------------------
// hlsh_pkg : shared types and constants for the Hamming LSH neighbour search
// Payload word types, register indexes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none
package hlsh_pkg;

  localparam int unsigned POINT_BITS_DEF   = 64;
  localparam int unsigned MAX_POINTS_DEF   = 1024;
  localparam int unsigned MAX_TABLES_DEF   = 16;
  localparam int unsigned MAX_KEY_BITS_DEF = 32;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] REG_KEY_BITS   = 2'd0;
  localparam logic [1:0] REG_TABLE_CNT  = 2'd1;
  localparam logic [1:0] REG_DIST_LIMIT = 2'd2;

  localparam logic [5:0] KEY_BITS_RST   = 6'd20;
  localparam logic [4:0] TABLE_CNT_RST  = 5'd8;
  localparam logic [6:0] DIST_LIMIT_RST = 7'd16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] point;
    logic [3:0]  table_number;
    logic [4:0]  bit_slot;
    logic [5:0]  sample_position;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  word_index;
    logic [63:0] neighbor_mask;
    logic        last;
  } out_word_t;

endpackage
`default_nettype wire

FILE: hdl/hamming_lsh_near_neighbor_top.sv
// ----------------------------------------------------------------------------
// hamming_lsh_near_neighbor_top : bit-sampling LSH near-neighbour search
//
// Input channel in_* (valid/ready) carries one in_word_t: load a sample
// position, insert a point, query, or clear the store. Result channel out_*
// carries out_word_t words. Registers key_bits, table_count, distance_limit
// sit on the APB-style cfg_ port at byte addresses 0, 4 and 8.
// A load or a clear is done in the idle state. After reset the
// sample-position RAM is swept to zero, during which in_ready is low.
// An insert walks MAX_TABLES tables, reading key bits through the one
// sample-position read port. A query builds its own keys the same way,
// then scans the stored points, one key-store read a cycle while it compares
// a point's keys, and emits one result word per 64 points. A rejected insert
// gives one status word.
// A stalled receiver holds the block in the output state; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none
module hamming_lsh_near_neighbor_top
  import hlsh_pkg::*;
#(
  parameter int unsigned POINT_BITS   = POINT_BITS_DEF,
  parameter int unsigned MAX_POINTS   = MAX_POINTS_DEF,
  parameter int unsigned MAX_TABLES   = MAX_TABLES_DEF,
  parameter int unsigned MAX_KEY_BITS = MAX_KEY_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int unsigned TB   = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int unsigned SB   = (MAX_KEY_BITS > 1) ? $clog2(MAX_KEY_BITS) : 1;
  localparam int unsigned SPD  = (1 << TB) * (1 << SB);
  localparam int unsigned SPA  = TB + SB;
  localparam int unsigned PB   = $clog2(MAX_POINTS);
  localparam int unsigned CB   = PB + 1;
  localparam int unsigned KSD  = (1 << PB) * (1 << TB);
  localparam int unsigned KSA  = PB + TB;
  localparam int unsigned WB   = (PB > 6) ? PB - 6 : 1;
  localparam int unsigned NWMAX = (MAX_POINTS + 63) / 64;
  localparam logic [63:0] PMASK = (POINT_BITS >= 64) ? {64{1'b1}} :
                                  ((64'd1 << POINT_BITS) - 64'd1);

  typedef enum logic [8:0] {
    ST_INIT  = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_HASH  = 9'b000000100,
    ST_HWAIT = 9'b000001000,
    ST_SCAN  = 9'b000010000,
    ST_DIST  = 9'b000100000,
    ST_EMIT  = 9'b001000000,
    ST_FULL  = 9'b010000000,
    ST_WRPT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [5:0] key_bits_r;
  logic [4:0] table_cnt_r;
  logic [6:0] dist_lim_r;
  logic       cfg_wr;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bits_r  <= KEY_BITS_RST;
      table_cnt_r <= TABLE_CNT_RST;
      dist_lim_r  <= DIST_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_KEY_BITS:   key_bits_r  <= cfg_pwdata[5:0];
        REG_TABLE_CNT:  table_cnt_r <= cfg_pwdata[4:0];
        REG_DIST_LIMIT: dist_lim_r  <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_KEY_BITS:   cfg_prdata = {26'd0, key_bits_r};
      REG_TABLE_CNT:  cfg_prdata = {27'd0, table_cnt_r};
      REG_DIST_LIMIT: cfg_prdata = {25'd0, dist_lim_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // effective k and table count
  logic [6:0] eff_k, eff_t;
  always_comb begin
    eff_k = {1'b0, key_bits_r};
    if (key_bits_r == 6'd0) eff_k = 7'd1;
    else if ({1'b0, key_bits_r} > 7'(MAX_KEY_BITS)) eff_k = 7'(MAX_KEY_BITS);
    eff_t = {2'b0, table_cnt_r};
    if (table_cnt_r == 5'd0) eff_t = 7'd1;
    else if ({2'b0, table_cnt_r} > 7'(MAX_TABLES)) eff_t = 7'(MAX_TABLES);
  end

  // working registers
  logic [1:0]        kind_r;
  logic [63:0]       pt_r;
  logic [CB-1:0]     cnt_r, cnt_nxt;
  logic [TB:0]       tbl_r, tbl_nxt;
  logic [SB:0]       slot_r, slot_nxt;
  logic [SPA:0]      init_r, init_nxt;
  logic [MAX_KEY_BITS-1:0] key_r, key_nxt;
  logic [MAX_KEY_BITS-1:0] qkey_r [MAX_TABLES];
  logic [PB:0]       idx_r, idx_nxt;
  logic [TB:0]       kt_r, kt_nxt;
  logic              hit_r, hit_nxt;
  logic [63:0]       mask_r, mask_nxt;
  logic [WB:0]       wi_r, wi_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              sp_rd_pend_r, sp_rd_pend_nxt;
  logic [6:0]        pop_r;

  // sample-position RAM
  logic          sp_we;
  logic [SPA-1:0] sp_waddr, sp_raddr;
  logic [5:0]    sp_wdata, sp_rdata;
  hlsh_ram #(.WIDTH(6), .DEPTH(SPD)) u_sp_ram (
    .clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
    .raddr(sp_raddr), .rdata(sp_rdata)
  );

  // point RAM
  logic          pt_we;
  logic [PB-1:0] pt_addr_w, pt_addr_r;
  logic [63:0]   pt_rdata;
  hlsh_ram #(.WIDTH(64), .DEPTH(1 << PB)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(pt_addr_w), .wdata(pt_r),
    .raddr(pt_addr_r), .rdata(pt_rdata)
  );

  // key RAM
  logic                    ks_we;
  logic [KSA-1:0]          ks_waddr, ks_raddr;
  logic [MAX_KEY_BITS-1:0] ks_rdata;
  hlsh_ram #(.WIDTH(MAX_KEY_BITS), .DEPTH(KSD)) u_ks_ram (
    .clk(clk), .we(ks_we), .waddr(ks_waddr), .wdata(key_r),
    .raddr(ks_raddr), .rdata(ks_rdata)
  );

  logic in_fire, out_fire;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_valid = (state_r == ST_EMIT) | (state_r == ST_FULL);
  assign out_fire  = out_valid & out_ready;

  logic [WB:0] nwords;
  always_comb begin
    nwords = (WB+1)'((cnt_r + CB'(63)) >> 6);
    if (nwords == '0) nwords = (WB+1)'(1);
    if (nwords > (WB+1)'(NWMAX)) nwords = (WB+1)'(NWMAX);
  end

  logic [63:0] dist_x;
  logic        sp_bit;
  assign dist_x = pt_r ^ pt_rdata;
  assign sp_bit = pt_r[sp_rdata];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    tbl_nxt        = tbl_r;
    slot_nxt       = slot_r;
    init_nxt       = init_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    kt_nxt         = kt_r;
    hit_nxt        = hit_r;
    mask_nxt       = mask_r;
    wi_nxt         = wi_r;
    rd_pend_nxt    = 1'b0;
    sp_rd_pend_nxt = 1'b0;
    sp_we    = 1'b0;
    sp_waddr = init_r[SPA-1:0];
    sp_wdata = 6'd0;
    sp_raddr = {tbl_r[TB-1:0], slot_r[SB-1:0]};
    pt_we    = 1'b0;
    pt_addr_w = cnt_r[PB-1:0];
    pt_addr_r = idx_r[PB-1:0];
    ks_we    = 1'b0;
    ks_waddr = {cnt_r[PB-1:0], tbl_r[TB-1:0]};
    ks_raddr = {idx_r[PB-1:0], kt_r[TB-1:0]};
    case (state_r)
      ST_INIT: begin
        sp_we    = 1'b1;
        init_nxt = init_r + 1'b1;
        if (init_r == (SPA+1)'(SPD - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.kind)
            KIND_LOAD: begin
              if (32'(in_data.table_number) < MAX_TABLES &&
                  32'(in_data.bit_slot) < MAX_KEY_BITS) begin
                sp_we    = 1'b1;
                sp_waddr = {TB'(in_data.table_number), SB'(in_data.bit_slot)};
                sp_wdata = in_data.sample_position;
              end
            end
            KIND_CLEAR: cnt_nxt = '0;
            KIND_INSERT: begin
              if (cnt_r >= CB'(MAX_POINTS)) state_nxt = ST_FULL;
              else begin
                state_nxt = ST_HASH; tbl_nxt = '0; slot_nxt = '0; key_nxt = '0;
              end
            end
            default: begin
              state_nxt = ST_HASH; tbl_nxt = '0; slot_nxt = '0; key_nxt = '0;
            end
          endcase
        end
      end
      ST_HASH: begin
        // one sample-position read a cycle, shift bit into key
        if (sp_rd_pend_r) key_nxt = (key_r << 1) | MAX_KEY_BITS'(sp_bit);
        if ({1'b0, slot_r} < (SB+2)'(eff_k)) begin
          sp_rd_pend_nxt = 1'b1;
          slot_nxt = slot_r + 1'b1;
        end else if (!sp_rd_pend_r) begin
          state_nxt = ST_HWAIT;
        end
      end
      ST_HWAIT: begin
        if (kind_r == KIND_INSERT) ks_we = 1'b1;
        slot_nxt = '0; key_nxt = '0;
        tbl_nxt  = tbl_r + 1'b1;
        if (tbl_r == (TB+1)'(MAX_TABLES - 1)) begin
          if (kind_r == KIND_INSERT) state_nxt = ST_WRPT;
          else begin
            state_nxt = ST_SCAN; idx_nxt = '0; kt_nxt = '0; hit_nxt = 1'b0;
            mask_nxt = '0; wi_nxt = '0;
          end
        end else state_nxt = ST_HASH;
      end
      ST_WRPT: begin
        pt_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        // sweep one point: key reads one per cycle, compare as they arrive
        if (rd_pend_r && ks_rdata == qkey_r[kt_r[TB-1:0] - 1'b1]) hit_nxt = 1'b1;
        if ({1'b0, idx_r} >= (PB+1)'(cnt_r) || idx_r[5:0] == 6'd0 &&
            idx_r[PB:6] != (PB-5)'(wi_r) ) begin
          state_nxt = ST_EMIT;
        end else if (7'(kt_r) < eff_t) begin
          rd_pend_nxt = 1'b1;
          kt_nxt = kt_r + 1'b1;
        end else if (!rd_pend_r) begin
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: begin
        // popcount is registered; read it from pop_r
        if (rd_pend_r) begin
          if (hit_r && (dist_lim_r[6] || pop_r <= dist_lim_r))
            mask_nxt[idx_r[5:0]] = 1'b1;
          idx_nxt = idx_r + 1'b1; kt_nxt = '0; hit_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end else rd_pend_nxt = 1'b1;
      end
      ST_EMIT: begin
        if (out_fire) begin
          mask_nxt = '0;
          wi_nxt   = wi_r + 1'b1;
          if (wi_r + 1'b1 == nwords) state_nxt = ST_IDLE;
          else state_nxt = ST_SCAN;
        end
      end
      ST_FULL: if (out_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_data = '0;
    if (state_r == ST_FULL) begin
      out_data.status = 1'b1;
      out_data.last   = 1'b1;
    end else begin
      out_data.word_index    = 4'(wi_r);
      out_data.neighbor_mask = mask_r;
      out_data.last          = (wi_r + 1'b1 == nwords);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      init_r  <= '0;
      cnt_r   <= '0;
      rd_pend_r <= 1'b0;
      sp_rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      cnt_r   <= cnt_nxt;
      rd_pend_r <= rd_pend_nxt;
      sp_rd_pend_r <= sp_rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_data.kind;
      pt_r   <= in_data.point & PMASK;
    end
    tbl_r  <= tbl_nxt;
    slot_r <= slot_nxt;
    key_r  <= key_nxt;
    idx_r  <= idx_nxt;
    kt_r   <= kt_nxt;
    hit_r  <= hit_nxt;
    mask_r <= mask_nxt;
    wi_r   <= wi_nxt;
    pop_r  <= 7'($countones(dist_x));
    if (state_r == ST_HWAIT && kind_r == KIND_QUERY) qkey_r[tbl_r[TB-1:0]] <= key_r;
  end

`ifndef NO_ASSERTIONS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CB'(MAX_POINTS)) else $error("store count overflow");
  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FULL) |-> (out_data.status && out_data.last))
    else $error("bad reject word");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif

endmodule
`default_nettype wire

FILE: hdl/hlsh_ram.sv
// ----------------------------------------------------------------------------
// hlsh_ram : generic single-port-write, one-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module hlsh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: dv/hamming_lsh_near_neighbor_top_test.sv
// ----------------------------------------------------------------------------
// hamming_lsh_near_neighbor_top_test : self-checking bench for the LSH search
// Drives loads, inserts, queries and clears under several register settings,
// predicts every result word in the bench and checks each word as it leaves.
// ----------------------------------------------------------------------------
module hamming_lsh_near_neighbor_top_test;
  import hlsh_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  out_word_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  hamming_lsh_near_neighbor_top dut (.*);

  // bench copy of the block state
  logic [5:0]  positions [MAX_TABLES_DEF][MAX_KEY_BITS_DEF];
  logic [63:0] stored_points [MAX_POINTS_DEF];
  logic [31:0] stored_keys [MAX_POINTS_DEF][MAX_TABLES_DEF];
  int unsigned n_stored;
  logic [5:0]  key_bits_q;
  logic [4:0]  table_cnt_q;
  logic [6:0]  dist_limit_q;

  out_word_t   pending_words[$];
  int          fail_count;
  bit          quiet;

  initial forever #5 clk = ~clk;

  function automatic void expect_word(out_word_t o);
    pending_words = {pending_words, o};
  endfunction

  function automatic logic [31:0] sample_key(logic [63:0] p, int t, int k);
    logic [31:0] key;
    key = '0;
    for (int s = 0; s < k; s++) key = {key[30:0], p[positions[t][s]]};
    return key;
  endfunction

  function automatic void predict_words(in_word_t w);
    int k, tc, nw;
    logic [31:0] qkey [MAX_TABLES_DEF];
    logic [63:0] mask [16];
    bit hit;
    out_word_t o;
    k  = (key_bits_q == 0) ? 1 : (key_bits_q > MAX_KEY_BITS_DEF) ? MAX_KEY_BITS_DEF : key_bits_q;
    tc = (table_cnt_q == 0) ? 1 : (table_cnt_q > MAX_TABLES_DEF) ? MAX_TABLES_DEF : table_cnt_q;
    case (w.kind)
      KIND_LOAD: positions[w.table_number][w.bit_slot] = w.sample_position;
      KIND_CLEAR: n_stored = 0;
      KIND_INSERT: begin
        if (n_stored >= MAX_POINTS_DEF) begin
          o.status = 1'b1; o.word_index = '0; o.neighbor_mask = '0; o.last = 1'b1;
          expect_word(o);
        end else begin
          stored_points[n_stored] = w.point;
          for (int t = 0; t < MAX_TABLES_DEF; t++)
            stored_keys[n_stored][t] = sample_key(w.point, t, k);
          n_stored++;
        end
      end
      default: begin
        for (int t = 0; t < tc; t++) qkey[t] = sample_key(w.point, t, k);
        for (int i = 0; i < 16; i++) mask[i] = '0;
        for (int i = 0; i < n_stored; i++) begin
          hit = 0;
          for (int t = 0; t < tc; t++) if (stored_keys[i][t] == qkey[t]) hit = 1;
          if (hit && $countones(w.point ^ stored_points[i]) <= dist_limit_q)
            mask[i / 64][i % 64] = 1'b1;
        end
        nw = (n_stored + 63) / 64;
        if (nw < 1) nw = 1;
        for (int i = 0; i < nw; i++) begin
          o.status = 1'b0; o.word_index = i[3:0]; o.neighbor_mask = mask[i];
          o.last = (i == nw - 1);
          expect_word(o);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) report_mismatch("result word with none expected");
      else begin
        e = pending_words.pop_front();
        if (out_data.status !== e.status)
          report_mismatch($sformatf("status %0b want %0b", out_data.status, e.status));
        if (out_data.word_index !== e.word_index)
          report_mismatch($sformatf("word_index %0d want %0d", out_data.word_index,
                                    e.word_index));
        if (out_data.neighbor_mask !== e.neighbor_mask)
          report_mismatch($sformatf("mask %h want %h", out_data.neighbor_mask,
                                    e.neighbor_mask));
        if (out_data.last !== e.last)
          report_mismatch($sformatf("last %0b want %0b", out_data.last, e.last));
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    @(posedge rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_word(in_word_t w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_words(w);
  endtask

  // stop sending and let the block settle; an insert may still be running
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_KEY_BITS:  key_bits_q = value[5:0];
      REG_TABLE_CNT: table_cnt_q = value[4:0];
      default:       dist_limit_q = value[6:0];
    endcase
  endtask

  task automatic set_regs(logic [31:0] kb, logic [31:0] tc, logic [31:0] dl);
    settle();
    write_reg(REG_KEY_BITS, kb);
    write_reg(REG_TABLE_CNT, tc);
    write_reg(REG_DIST_LIMIT, dl);
  endtask

  function automatic in_word_t make_word(logic [1:0] kind, logic [63:0] p);
    in_word_t w;
    w.kind = kind; w.point = p;
    w.table_number = 4'($urandom); w.bit_slot = 5'($urandom);
    w.sample_position = 6'($urandom);
    return w;
  endfunction

  function automatic logic [63:0] flip_some(logic [63:0] p, int most);
    repeat ($urandom_range(0, most)) p[$urandom_range(0, 63)] ^= 1'b1;
    return p;
  endfunction

  task automatic load_pos(int t, int s, int pos);
    in_word_t w;
    w = make_word(KIND_LOAD, {$urandom, $urandom});
    w.table_number = 4'(t); w.bit_slot = 5'(s); w.sample_position = 6'(pos);
    send_word(w);
  endtask

  task automatic test_directed();
    send_word(make_word(KIND_QUERY, '0));      // empty store gives one zero word
    send_word(make_word(KIND_INSERT, '0));
    send_word(make_word(KIND_INSERT, '1));
    send_word(make_word(KIND_INSERT, 64'h5555_5555_5555_5555));
    send_word(make_word(KIND_QUERY, '0));
    send_word(make_word(KIND_QUERY, '1));
    load_pos(15, 31, 63);
    load_pos(0, 0, 63);
    load_pos(1, 0, 0);
    send_word(make_word(KIND_INSERT, 64'h8000_0000_0000_0001));
    send_word(make_word(KIND_QUERY, 64'h8000_0000_0000_0000));
    set_regs(0, 0, 0);                         // clamped up to one bit, one table
    send_word(make_word(KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA));
    send_word(make_word(KIND_QUERY, 64'hAAAA_AAAA_AAAA_AAAA));
    set_regs(63, 31, 127);                     // clamped down, every distance
    send_word(make_word(KIND_QUERY, 64'h0123_4567_89AB_CDEF));
    set_regs(32, 16, 64);
    send_word(make_word(KIND_QUERY, '1));
    send_word(make_word(KIND_CLEAR, '0));
    send_word(make_word(KIND_QUERY, '1));
  endtask

  task automatic test_random_phase(int kb, int tc, int dl, int n_items);
    logic [63:0] bases [4];
    int r;
    set_regs(kb, tc, dl);
    send_word(make_word(KIND_CLEAR, '0));
    for (int i = 0; i < 4; i++) bases[i] = {$urandom, $urandom};
    for (int i = 0; i < 6; i++)
      load_pos($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 63));
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        send_word(make_word(KIND_INSERT, r < 30 ? flip_some(bases[$urandom_range(0, 3)], 12)
                                                : {$urandom, $urandom}));
      else if (r < 72)
        send_word(make_word(KIND_QUERY, r < 68 ? flip_some(bases[$urandom_range(0, 3)], 12)
                                               : {$urandom, $urandom}));
      else if (r < 96)
        load_pos($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 63));
      else
        send_word(make_word(KIND_CLEAR, '0));
      if (i == n_items / 2) begin             // hold off until all results are in
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) @(posedge clk);
      end
    end
  endtask

  // last stretch with no random gaps or stalls on either side
  task automatic test_steady_tail();
    quiet = 1;
    test_random_phase(20, 8, 16, 50);
  endtask

  initial begin
    for (int t = 0; t < MAX_TABLES_DEF; t++)
      for (int s = 0; s < MAX_KEY_BITS_DEF; s++) positions[t][s] = '0;
    n_stored = 0; fail_count = 0; quiet = 0;
    key_bits_q = KEY_BITS_RST; table_cnt_q = TABLE_CNT_RST; dist_limit_q = DIST_LIMIT_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_phase(20, 8, 16, 52);
    test_random_phase(1, 1, 0, 52);
    test_random_phase(32, 16, 64, 52);
    test_random_phase(6, 4, 12, 52);
    test_random_phase($urandom_range(1, 32), $urandom_range(1, 16), $urandom_range(0, 30), 52);
    test_random_phase(12, 31, 20, 52);
    test_random_phase($urandom_range(0, 63), $urandom_range(0, 31), $urandom_range(0, 127), 52);
    test_steady_tail();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #500_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
